@@ src/imr_pkg.sv @@
// ----------------------------------------------------------------------------
// imr_pkg: shared types and constants of the interval map
// Beat payloads, the cell command and the fixed field widths.
// ----------------------------------------------------------------------------
package imr_pkg;

  localparam int KEY_W       = 32;
  localparam int VAL_W       = 8;
  localparam int COUNT_W     = 7;
  localparam int DEPTH_DEF   = 64;

  localparam logic MODE_ASSIGN = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [2:0] OP_HOLD = 3'd0;
  localparam logic [2:0] OP_CMP  = 3'd1;
  localparam logic [2:0] OP_SHL  = 3'd2;
  localparam logic [2:0] OP_SHR  = 3'd3;
  localparam logic [2:0] OP_CLR  = 3'd4;

  typedef struct packed {
    logic             mode;
    logic [KEY_W-1:0] range_begin;
    logic [KEY_W-1:0] range_end;
    logic [VAL_W-1:0] new_value;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   found_value;
    logic               table_full;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ins_here;
  } ctl_t;

endpackage

@@ src/interval_map_range_assign_top.sv @@
// ----------------------------------------------------------------------------
// interval_map_range_assign_top: sorted breakpoint table with range assign
// A row of cells holds the table; a sequencer compares, deletes and inserts.
// ----------------------------------------------------------------------------
// One item is handled at a time. A lookup, an empty range and a refused
// assign go from the compare and evaluate states straight to the result
// beat. An assign that goes ahead first runs a delete pass that removes the
// breakpoints its range covers (the cells shift the table left one slot per
// cycle). Two right-shift steps then follow, one for the end boundary and
// one for the begin boundary, each inserting an entry only when one is
// needed. All cells compare in parallel; the range boundaries are encoded
// in the cycle after.
// cfg_we clears the table to a single entry of key zero holding cfg_wdata.
module interval_map_range_assign_top import imr_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_we,
  input  logic [VAL_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_EVAL = 3'd2;
  localparam logic [2:0] ST_DEL  = 3'd3;
  localparam logic [2:0] ST_INSE = 3'd4;
  localparam logic [2:0] ST_INSB = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic             mode;
  logic [KEY_W-1:0] kb;
  logic [KEY_W-1:0] ke;
  logic [VAL_W-1:0] nval;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    rem;
  logic             do_b;
  logic             do_e;
  logic [VAL_W-1:0] old_val;
  logic [CW-1:0]    count_next;
  logic [VAL_W-1:0] res_found;
  logic             res_full;

  ctl_t             ctl;
  logic [KEY_W-1:0] ins_key;
  logic [VAL_W-1:0] ins_val;

  logic [KEY_W-1:0] keys [TABLE_DEPTH+1];
  logic [VAL_W-1:0] vals [TABLE_DEPTH+1];
  logic             vlds [TABLE_DEPTH+1];
  logic             ltx  [TABLE_DEPTH+1];
  logic             lex  [TABLE_DEPTH+1];

  // Slot past the last cell reads as empty.
  assign keys[TABLE_DEPTH] = '0;
  assign vals[TABLE_DEPTH] = '0;
  assign vlds[TABLE_DEPTH] = 1'b0;
  assign ltx[TABLE_DEPTH]  = 1'b0;
  assign lex[TABLE_DEPTH]  = 1'b0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      imr_cell #(.IDX(g), .PW(CW)) u_cell (
        .clk, .rst, .ctl, .pos, .base(cfg_wdata), .kb, .ke,
        .l_key('0), .l_val('0), .l_vld(1'b0),
        .r_key(keys[g+1]), .r_val(vals[g+1]), .r_vld(vlds[g+1]),
        .ins_key, .ins_val,
        .key(keys[g]), .val(vals[g]), .vld(vlds[g]), .lt(ltx[g]), .le(lex[g])
      );
    end else begin : g_rest
      imr_cell #(.IDX(g), .PW(CW)) u_cell (
        .clk, .rst, .ctl, .pos, .base(cfg_wdata), .kb, .ke,
        .l_key(keys[g-1]), .l_val(vals[g-1]), .l_vld(vlds[g-1]),
        .r_key(keys[g+1]), .r_val(vals[g+1]), .r_vld(vlds[g+1]),
        .ins_key, .ins_val,
        .key(keys[g]), .val(vals[g]), .vld(vlds[g]), .lt(ltx[g]), .le(lex[g])
      );
    end
  end

  // Boundary encoding: the flags form a prefix, so each has one edge.
  logic [CW-1:0]    lo_c;
  logic [CW-1:0]    hi_c;
  logic [VAL_W-1:0] below_c;
  logic [VAL_W-1:0] old_c;
  logic [KEY_W-1:0] endkey_c;
  logic             b_c;
  logic             e_c;
  logic [CW-1:0]    rem_c;
  logic [CW:0]      n_c;

  always_comb begin
    lo_c     = '0;
    hi_c     = '0;
    below_c  = '0;
    old_c    = '0;
    endkey_c = '0;
    for (int j = 1; j <= TABLE_DEPTH; j++) begin
      if (ltx[j-1] && !ltx[j]) begin
        lo_c    = lo_c | CW'(j);
        below_c = below_c | vals[j-1];
      end
      if (lex[j-1] && !lex[j]) begin
        hi_c     = hi_c | CW'(j);
        old_c    = old_c | vals[j-1];
        endkey_c = endkey_c | keys[j-1];
      end
    end
    b_c   = !(lo_c != '0 && below_c == nval);
    e_c   = (old_c != nval) && ((endkey_c == ke) || (ke != {KEY_W{1'b1}}));
    rem_c = hi_c - lo_c;
    n_c   = {1'b0, count} - {1'b0, rem_c} + (CW+1)'(b_c) + (CW+1)'(e_c);
  end

  always_comb begin
    ctl.op       = OP_HOLD;
    ctl.ins_here = 1'b0;
    ins_key      = kb;
    ins_val      = nval;
    if (cfg_we) begin
      ctl.op = OP_CLR;
    end else begin
      case (state)
        ST_CMP:  ctl.op = OP_CMP;
        ST_DEL:  ctl.op = (rem != '0) ? OP_SHL : OP_HOLD;
        ST_INSE: begin
          ctl.op       = OP_SHR;
          ctl.ins_here = do_e;
          ins_key      = ke;
          ins_val      = old_val;
        end
        ST_INSB: begin
          ctl.op       = OP_SHR;
          ctl.ins_here = do_b;
        end
        default: ctl.op = OP_HOLD;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        count <= CW'(1);
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            mode  <= in_data.mode;
            kb    <= in_data.range_begin;
            ke    <= (in_data.mode == MODE_LOOKUP) ? in_data.range_begin
                                                   : in_data.range_end;
            nval  <= in_data.new_value;
            state <= ST_CMP;
          end
        end
        ST_CMP: state <= ST_EVAL;
        ST_EVAL: begin
          pos        <= lo_c;
          rem        <= rem_c;
          do_b       <= b_c;
          do_e       <= e_c;
          old_val    <= old_c;
          count_next <= n_c[CW-1:0];
          res_found  <= (mode == MODE_LOOKUP) ? old_c : '0;
          res_full   <= (mode != MODE_LOOKUP) && (kb < ke) &&
                        (n_c > (CW+1)'(TABLE_DEPTH));
          if (mode == MODE_LOOKUP) begin
            state <= ST_FIN;
          end else if (kb >= ke) begin
            state <= ST_FIN;
          end else if (n_c > (CW+1)'(TABLE_DEPTH)) begin
            state <= ST_FIN;
          end else begin
            state <= ST_DEL;
          end
        end
        ST_DEL: begin
          if (rem != '0) begin
            rem <= rem - CW'(1);
          end else begin
            state <= ST_INSE;
          end
        end
        ST_INSE: state <= ST_INSB;
        ST_INSB: begin
          count <= count_next;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.found_value  <= res_found;
            out_data.table_full   <= res_full;
            out_data.entry_count  <= COUNT_W'(count);
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The table never becomes empty.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    count != '0) else $error("entry count reached zero");

  // A refused assign reports no found value.
  a_full_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.table_full |-> out_data.found_value == '0)
    else $error("refused assign carries a value");

  // Entry zero always holds key zero.
  a_first_entry: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> vlds[0] && keys[0] == '0)
    else $error("first breakpoint lost");

  // An accepted beat always starts the compare pass.
  a_accept_cmp: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_CMP)
    else $error("accepted beat did not start compare");

endmodule

@@ src/imr_cell.sv @@
// ----------------------------------------------------------------------------
// imr_cell: one breakpoint slot of the table
// Holds a key, a value and a valid bit, compares them against the item keys
// and moves its entry to or from its neighbors on shift commands.
// ----------------------------------------------------------------------------
module imr_cell import imr_pkg::*; #(
  parameter int IDX = 0,
  parameter int PW  = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  logic [PW-1:0]    pos,
  input  logic [VAL_W-1:0] base,
  input  logic [KEY_W-1:0] kb,
  input  logic [KEY_W-1:0] ke,
  input  logic [KEY_W-1:0] l_key,
  input  logic [VAL_W-1:0] l_val,
  input  logic             l_vld,
  input  logic [KEY_W-1:0] r_key,
  input  logic [VAL_W-1:0] r_val,
  input  logic             r_vld,
  input  logic [KEY_W-1:0] ins_key,
  input  logic [VAL_W-1:0] ins_val,
  output logic [KEY_W-1:0] key,
  output logic [VAL_W-1:0] val,
  output logic             vld,
  output logic             lt,
  output logic             le
);

  localparam logic [PW-1:0] MY = PW'(IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= (IDX == 0);
      key <= '0;
      val <= '0;
      lt  <= 1'b0;
      le  <= 1'b0;
    end else begin
      case (ctl.op)
        OP_CMP: begin
          lt <= vld && (key < kb);
          le <= vld && (key <= ke);
        end
        OP_SHL: begin
          if (MY >= pos) begin
            key <= r_key;
            val <= r_val;
            vld <= r_vld;
          end
        end
        OP_SHR: begin
          if (ctl.ins_here && MY == pos) begin
            key <= ins_key;
            val <= ins_val;
            vld <= 1'b1;
          end else if (ctl.ins_here && MY > pos) begin
            key <= l_key;
            val <= l_val;
            vld <= l_vld;
          end
        end
        OP_CLR: begin
          vld <= (IDX == 0);
          key <= '0;
          val <= base;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
